// ===== src/ftdf_pkg.sv =====
`default_nettype none

package ftdf_pkg;

  localparam int DEF_CAPACITY = 256;
  localparam int FP_W         = 32;
  localparam int TRIPLE_W     = 3 * FP_W;
  localparam int UCNT_W       = 16;
  localparam logic [UCNT_W-1:0] UCNT_MAX = {UCNT_W{1'b1}};

  localparam logic [FP_W-1:0] EXP_MASK = 32'h7F80_0000;
  localparam logic [FP_W-1:0] MAN_MASK = 32'h007F_FFFF;

  typedef logic [TRIPLE_W-1:0] triple_t;

  // probe token walking down the cell chain
  typedef struct packed {
    logic run;
    logic hit;
  } probe_t;

  function automatic logic fp_is_nan(input logic [FP_W-1:0] x);
    fp_is_nan = ((x & EXP_MASK) == EXP_MASK) && ((x & MAN_MASK) != '0);
  endfunction

  // stored entries never hold a NaN, and the hit of a NaN query is ignored
  function automatic logic fp_eq(input logic [FP_W-1:0] a, input logic [FP_W-1:0] b);
    fp_eq = (a == b) || ((a[FP_W-2:0] == '0) && (b[FP_W-2:0] == '0));
  endfunction

  function automatic logic triple_eq(input triple_t a, input triple_t b);
    triple_eq = fp_eq(a[FP_W-1:0], b[FP_W-1:0]) &&
                fp_eq(a[2*FP_W-1:FP_W], b[2*FP_W-1:FP_W]) &&
                fp_eq(a[3*FP_W-1:2*FP_W], b[3*FP_W-1:2*FP_W]);
  endfunction

endpackage

`default_nettype wire

// ===== src/float_triple_duplicate_filter_core.sv =====
// Duplicate filter for triples of IEEE single bit patterns.
// in_*  : one transaction carries a triple; in_tdata holds first, second,
//         third value from bit 0 up.
// out_* : one transaction per input with is_new, overflow and the running
//         unique count (saturating at 65535).
// Matching uses float equality: -0 equals +0, NaN equals nothing. A triple
// with a NaN is reported new and counted but not stored. An unseen triple
// arriving at a full table is flagged overflow and dropped.
// The table is a chain of CAPACITY cells; a probe token steps one cell per
// cycle. An accepted item walks the whole chain before its result is
// committed, and the block takes no new item until that commit. The probe
// walk down the chain sets both the latency and the spacing of items.
// in_tready is high only while no item is in work. A result waiting on a
// stalled out_tready does not stop the next item from being accepted and
// scanned; its commit then waits until the output register frees.
// Reset empties the table (fill count to zero) and clears the count; no
// clearing pass is needed.
`default_nettype none

module float_triple_duplicate_filter_core #(
  parameter int CAPACITY = ftdf_pkg::DEF_CAPACITY
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [95:0] in_tdata,   // first_value, second_value, third_value
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata   // is_new, overflow, unique_count[15:0], zero pad
);
  import ftdf_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  triple_t           query_r;
  logic              nan_r;
  logic              launch_r;
  logic              hit_r, hit_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [UCNT_W-1:0] total_r, total_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_new_r, out_new_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic [UCNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic              in_acc, out_free, commit, wr_en;
  logic              res_new, res_ovf;
  probe_t            tok [CAPACITY+1];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign commit    = (state_r == S_FIN) && out_free;

  assign tok[0] = '{run: launch_r, hit: 1'b0};

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      ftdf_cell #(
        .CAPACITY(CAPACITY),
        .IDX     (g),
        .CW      (CW),
        .IW      (IW)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query_r),
        .fill_cnt(cnt_r),
        .wr_en   (wr_en),
        .wr_idx  (cnt_r[IW-1:0]),
        .tok_in  (tok[g]),
        .tok_out (tok[g+1])
      );
    end
  endgenerate

  always_comb begin
    res_new = 1'b0;
    res_ovf = 1'b0;
    wr_en   = 1'b0;
    if (nan_r) begin
      res_new = 1'b1;
    end else if (!hit_r) begin
      if (cnt_r < CW'(CAPACITY)) begin
        res_new = 1'b1;
        wr_en   = commit;
      end else begin
        res_ovf = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    hit_nxt       = hit_r;
    cnt_nxt       = cnt_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_new_nxt   = out_new_r;
    out_ovf_nxt   = out_ovf_r;
    out_cnt_nxt   = out_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok[CAPACITY].run) begin
          hit_nxt   = tok[CAPACITY].hit;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          if (wr_en) begin
            cnt_nxt = cnt_r + CW'(1);
          end
          if (res_new && (total_r != UCNT_MAX)) begin
            total_nxt = total_r + UCNT_W'(1);
          end
          out_valid_nxt = 1'b1;
          out_new_nxt   = res_new;
          out_ovf_nxt   = res_ovf;
          out_cnt_nxt   = total_nxt;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      cnt_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= in_acc;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      query_r <= in_tdata;
      nan_r   <= fp_is_nan(in_tdata[31:0]) | fp_is_nan(in_tdata[63:32]) |
                 fp_is_nan(in_tdata[95:64]);
    end
    hit_r     <= hit_nxt;
    out_new_r <= out_new_nxt;
    out_ovf_r <= out_ovf_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_cnt_r, out_ovf_r, out_new_r};

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_new_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_new_r && out_ovf_r))
    else $error("result both new and overflow");

  a_probe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[CAPACITY].run |-> (state_r == S_SCAN))
    else $error("probe returned outside scan");

  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (launch_r && (state_r == S_SCAN)))
    else $error("accepted item not launched");

  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> (total_r == $past(total_r)))
    else $error("unique total moved without a commit");

endmodule

`default_nettype wire

// ===== src/ftdf_cell.sv =====
`default_nettype none

module ftdf_cell #(
  parameter int CAPACITY = ftdf_pkg::DEF_CAPACITY,
  parameter int IDX      = 0,
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int IW       = $clog2(CAPACITY)
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire ftdf_pkg::triple_t query,
  input  wire [CW-1:0]          fill_cnt,
  input  wire                   wr_en,
  input  wire [IW-1:0]          wr_idx,
  input  wire ftdf_pkg::probe_t tok_in,
  output ftdf_pkg::probe_t      tok_out
);
  import ftdf_pkg::*;

  triple_t entry_r;
  probe_t  tok_r;
  probe_t  tok_nxt;
  logic    slot_used;

  assign slot_used = CW'(IDX) < fill_cnt;

  always_comb begin
    tok_nxt.run = tok_in.run;
    tok_nxt.hit = tok_in.hit | (tok_in.run & slot_used & triple_eq(entry_r, query));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IW'(IDX))) begin
      entry_r <= query;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// ===== test/triple_filter_checker.sv =====
`default_nettype none

module triple_filter_checker #(
  parameter int CAPACITY = ftdf_pkg::DEF_CAPACITY
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  input  wire        in_tready,
  input  wire [95:0] in_tdata,   // first_value, second_value, third_value
  input  wire        out_tvalid,
  input  wire        out_tready,
  input  wire [23:0] out_tdata,  // is_new, overflow, unique_count[15:0], zero pad
  output int         mismatches,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  ftdf_pkg::triple_t seen_vals [CAPACITY];
  int                seen_used;
  logic [15:0]       uniq_total;
  logic [23:0]       verdict_q [$];

  initial mismatches = 0;
  initial outstanding = 0;

  function automatic logic nan_bits(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'h0);
  endfunction

  function automatic logic same_float(input logic [31:0] a, input logic [31:0] b);
    if (nan_bits(a) || nan_bits(b)) return 1'b0;
    return (a == b) || ((a[30:0] == 31'h0) && (b[30:0] == 31'h0));
  endfunction

  always @(posedge clk) begin
    logic [31:0] comp [3];
    logic        any_nan;
    logic        hit;
    logic        fresh;
    logic        ovf;
    logic [23:0] want;
    int          i;
    if (!rst_n) begin
      seen_used   = 0;
      uniq_total  = '0;
      outstanding = 0;
      verdict_q.delete();
    end else begin
      // results first: a result can never belong to a transaction taken at the same edge
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        end else begin
          want = verdict_q.pop_front();
          outstanding--;
          if (out_tdata[0] !== want[0] || out_tdata[1] !== want[1] ||
              out_tdata[17:2] !== want[17:2]) begin
            mismatches++;
            $display({"%0t: mismatch, expected is_new %b overflow %b count %0d,",
                      " actual is_new %b overflow %b count %0d"},
                     $time, want[0], want[1], want[17:2],
                     out_tdata[0], out_tdata[1], out_tdata[17:2]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        any_nan = 1'b0;
        for (i = 0; i < 3; i++) begin
          comp[i] = in_tdata[32*i +: 32];
          any_nan = any_nan | nan_bits(comp[i]);
        end
        hit   = 1'b0;
        fresh = 1'b0;
        ovf   = 1'b0;
        if (!any_nan) begin
          for (i = 0; i < seen_used; i++) begin
            if (same_float(seen_vals[i][31:0], comp[0]) &&
                same_float(seen_vals[i][63:32], comp[1]) &&
                same_float(seen_vals[i][95:64], comp[2]))
              hit = 1'b1;
          end
        end
        if (any_nan) begin
          fresh = 1'b1;
        end else if (!hit) begin
          if (seen_used < CAPACITY) begin
            seen_vals[seen_used] = in_tdata;
            seen_used++;
            fresh = 1'b1;
          end else begin
            ovf = 1'b1;
          end
        end
        if (fresh && uniq_total != ftdf_pkg::UCNT_MAX) uniq_total++;
        verdict_q.push_back({6'b0, uniq_total, ovf, fresh});
        outstanding++;
      end
    end
  end

endmodule

`default_nettype wire

// ===== test/float_triple_duplicate_filter_core_tb.sv =====
`default_nettype none

module float_triple_duplicate_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = ftdf_pkg::DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 700;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [95:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [23:0] out_tdata;
  int          mismatches;
  int          outstanding;
  bit          idle_on = 1'b1;

  ftdf_pkg::triple_t history_q [$];

  float_triple_duplicate_filter_core #(.CAPACITY(CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  triple_filter_checker #(.CAPACITY(CAP)) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [31:0] rand_component();
    case ($urandom_range(0, 7))
      5:       return {1'($urandom_range(0, 1)), 31'h0};
      6:       return {1'($urandom_range(0, 1)), 8'hFF, 23'h0};
      7:       return {1'($urandom_range(0, 1)), 31'($urandom_range(0, 3))};
      default: return $urandom();
    endcase
  endfunction

  task automatic push_triple(input ftdf_pkg::triple_t t);
    int gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    history_q.push_back(t);
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    ftdf_pkg::triple_t t;
    int                kind;
    int                k;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // {third, second, first}
    push_triple({32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
    push_triple({32'h8000_0000, 32'h0000_0000, 32'h8000_0000});
    push_triple({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    push_triple({32'hC040_0000, 32'h4000_0000, 32'h3F80_0000});
    push_triple({32'hC040_0000, 32'h4000_0000, 32'h3F80_0000});
    push_triple({32'h0000_0000, 32'h0000_0000, 32'h7FC0_0000});
    push_triple({32'h0000_0000, 32'h0000_0000, 32'h7FC0_0000});
    push_triple({32'h0000_0000, 32'h7F80_0001, 32'h0000_0000});
    push_triple({32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000});
    push_triple({32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000});
    push_triple({32'h7F7F_FFFF, 32'hFF80_0000, 32'h7F80_0000});
    push_triple({32'h7F7F_FFFF, 32'hFF80_0000, 32'h7F80_0000});
    push_triple({32'h007F_FFFF, 32'h8000_0001, 32'h0000_0001});
    push_triple({32'h007F_FFFF, 32'h8000_0001, 32'h8000_0001});
    push_triple({32'h007F_FFFF, 32'h8000_0001, 32'h0000_0001});
    push_triple({32'h0080_0000, 32'h807F_FFFF, 32'hFF7F_FFFF});
    push_triple({32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000});
    push_triple({32'hFF80_0000, 32'h7F80_0000, 32'h7F80_0000});
    push_triple({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    push_triple({32'h0000_0000, 32'h8000_0000, 32'h0000_0000});

    @(negedge clk);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = (n % 150) >= 40;
      if (n == RANDOM_ITEMS / 2) wait_drained();
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        t = {rand_component(), rand_component(), rand_component()};
      end else begin
        t = history_q[$urandom_range(0, history_q.size() - 1)];
        for (k = 0; k < 3; k++) begin
          if (t[32*k +: 31] == 31'h0 && $urandom_range(0, 1))
            t[32*k + 31] = ~t[32*k + 31];
        end
        if (kind >= 82) begin
          k = $urandom_range(0, 2);
          t[32*k +: 32] = {1'($urandom_range(0, 1)), 8'hFF,
                           23'($urandom_range(1, 23'h7F_FFFF))};
        end
      end
      push_triple(t);
    end

    wait_drained();
    repeat (CAP + 20) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== float_triple_duplicate_filter_core.f =====
src/ftdf_pkg.sv
src/ftdf_cell.sv
src/float_triple_duplicate_filter_core.sv
test/triple_filter_checker.sv
test/float_triple_duplicate_filter_core_tb.sv
